// ----- src/lps_pkg.sv -----
package lps_pkg;

  localparam int MAX_LIMIT   = 4095;
  localparam int PRIME_SLOTS = 1024;

  localparam int VAL_W     = $clog2(MAX_LIMIT + 1);
  localparam int CAND_W    = $clog2(MAX_LIMIT + 2);
  localparam int CNT_W     = $clog2(PRIME_SLOTS + 1);
  localparam int TBL_DEPTH = MAX_LIMIT + 1;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int PL_AW     = $clog2(PRIME_SLOTS);
  localparam int PROD_W    = 2 * VAL_W;

  typedef struct packed {
    logic              tbl_we;
    logic [TBL_AW-1:0] tbl_waddr;
    logic [VAL_W-1:0]  tbl_wdata;
    logic [TBL_AW-1:0] tbl_raddr;
    logic              pl_we;
    logic [PL_AW-1:0]  pl_waddr;
    logic [VAL_W-1:0]  pl_wdata;
    logic [PL_AW-1:0]  pl_raddr;
  } mem_req_t;

endpackage

// ----- src/lps_store.sv -----
module lps_store (
  input  logic                    clk,
  input  lps_pkg::mem_req_t       req,
  output logic [lps_pkg::VAL_W-1:0] tbl_rdata,
  output logic [lps_pkg::VAL_W-1:0] pl_rdata
);
  import lps_pkg::*;

  // smallest factor of each number
  logic [VAL_W-1:0] factor_mem [TBL_DEPTH];
  // primes found in order
  logic [VAL_W-1:0] prime_mem [PRIME_SLOTS];

  always_ff @(posedge clk) begin
    if (req.tbl_we) begin
      factor_mem[req.tbl_waddr] <= req.tbl_wdata;
    end
    tbl_rdata <= factor_mem[req.tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.pl_we) begin
      prime_mem[req.pl_waddr] <= req.pl_wdata;
    end
    pl_rdata <= prime_mem[req.pl_raddr];
  end

endmodule

// ----- src/linear_prime_sieve_unit.sv -----
// Linear sieve that records the smallest prime factor of every number up to
// sieve_limit. Each request examines the next candidate (or candidate 2 after
// a restart) and returns one result. The marking loop reads one prime from
// the prime list memory in state S_MREQ and multiplies, compares and writes
// the factor table in state S_MCHK. A step past the limit goes from S_EXAM
// straight to S_DONE. The result shows in the same cycle as the next request
// can be taken, and a step holds in S_DONE while the previous result is
// still stalled. After reset, and after every restart request before it is
// examined, the factor table is cleared one entry a cycle with in_stall high.
// Configuration writes are always taken and must only come while idle.
module linear_prime_sieve_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      restart,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lps_pkg::VAL_W-1:0] candidate,
  output logic                      prime_flag,
  output logic [lps_pkg::CNT_W-1:0] prime_count,
  output logic                      finished,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lps_pkg::VAL_W-1:0] sieve_limit
);
  import lps_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXAM  = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_MREQ  = 3'd4;
  localparam logic [2:0] S_MCHK  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state, state_next;
  logic [TBL_AW-1:0] clr_addr, clr_addr_next;
  logic              clr_exam, clr_exam_next;
  logic [CAND_W-1:0] ncand, ncand_next;
  logic [CNT_W-1:0]  pf, pf_next;
  logic [CNT_W-1:0]  j, j_next;
  logic [VAL_W-1:0]  cand, cand_next;
  logic [VAL_W-1:0]  factor, factor_next;
  logic              prime, prime_next;
  logic              fin, fin_next;
  logic [VAL_W-1:0]  limit;
  logic [VAL_W-1:0]  limit_act;
  logic [PROD_W-1:0] prod;
  logic              load_out;

  mem_req_t         req;
  logic [VAL_W-1:0] tbl_rdata;
  logic [VAL_W-1:0] pl_rdata;

  lps_store u_store (
    .clk       (clk),
    .req       (req),
    .tbl_rdata (tbl_rdata),
    .pl_rdata  (pl_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign limit_act = (limit > VAL_W'(MAX_LIMIT)) ? VAL_W'(MAX_LIMIT) : limit;
  assign prod      = PROD_W'(cand) * PROD_W'(pl_rdata);
  assign load_out  = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    clr_exam_next = clr_exam;
    ncand_next    = ncand;
    pf_next       = pf;
    j_next        = j;
    cand_next     = cand;
    factor_next   = factor;
    prime_next    = prime;
    fin_next      = fin;
    req           = '0;
    req.tbl_raddr = ncand[TBL_AW-1:0];
    req.pl_raddr  = j[PL_AW-1:0];
    unique case (state)
      S_CLEAR: begin
        req.tbl_we    = 1'b1;
        req.tbl_waddr = clr_addr;
        req.tbl_wdata = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == TBL_AW'(TBL_DEPTH - 1)) begin
          ncand_next = CAND_W'(2);
          pf_next    = '0;
          state_next = clr_exam ? S_EXAM : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          clr_addr_next = '0;
          clr_exam_next = 1'b1;
          state_next    = restart ? S_CLEAR : S_EXAM;
        end
      end
      S_EXAM: begin
        cand_next  = ncand[VAL_W-1:0];
        prime_next = 1'b0;
        if (ncand > CAND_W'(limit_act)) begin
          fin_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          fin_next   = 1'b0;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        j_next = '0;
        if (tbl_rdata == '0) begin
          prime_next    = 1'b1;
          factor_next   = cand;
          req.tbl_we    = 1'b1;
          req.tbl_waddr = cand;
          req.tbl_wdata = cand;
          if (pf < CNT_W'(PRIME_SLOTS)) begin
            req.pl_we    = 1'b1;
            req.pl_waddr = pf[PL_AW-1:0];
            req.pl_wdata = cand;
            pf_next      = pf + 1'b1;
          end
        end else begin
          factor_next = tbl_rdata;
        end
        state_next = S_MREQ;
      end
      S_MREQ: begin
        if (j >= pf) begin
          ncand_next = CAND_W'(cand) + 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_MCHK;
        end
      end
      S_MCHK: begin
        if ((pl_rdata > factor) || (prod > PROD_W'(limit_act))) begin
          ncand_next = CAND_W'(cand) + 1'b1;
          state_next = S_DONE;
        end else begin
          req.tbl_we    = 1'b1;
          req.tbl_waddr = prod[TBL_AW-1:0];
          req.tbl_wdata = pl_rdata;
          j_next        = j + 1'b1;
          state_next    = S_MREQ;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_exam  <= 1'b0;
      ncand     <= CAND_W'(2);
      pf        <= '0;
      j         <= '0;
      limit     <= VAL_W'(MAX_LIMIT);
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      clr_exam <= clr_exam_next;
      ncand    <= ncand_next;
      pf       <= pf_next;
      j        <= j_next;
      if (cfg_valid && cfg_ready) begin
        limit <= sieve_limit;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cand   <= cand_next;
    factor <= factor_next;
    prime  <= prime_next;
    fin    <= fin_next;
    if (load_out) begin
      candidate   <= fin ? '0 : cand;
      prime_flag  <= prime;
      prime_count <= pf;
      finished    <= fin;
    end
  end

`ifndef ASSERT_OFF
  a_pf_bound: assert property (@(posedge clk) disable iff (rst)
    pf <= CNT_W'(PRIME_SLOTS))
    else $error("prime count beyond list size");

  a_ncand_bound: assert property (@(posedge clk) disable iff (rst)
    ncand <= CAND_W'(MAX_LIMIT + 1))
    else $error("next candidate out of range");

  a_mark_above: assert property (@(posedge clk) disable iff (rst)
    (state == S_MCHK && req.tbl_we) |-> (prod > PROD_W'(cand)))
    else $error("marking write at or below candidate");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result shown outside done state");
`endif

endmodule

// ----- bench/lps_checker.sv -----
`timescale 1ns / 1ps

module lps_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      restart,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [lps_pkg::VAL_W-1:0] candidate,
  input  logic                      prime_flag,
  input  logic [lps_pkg::CNT_W-1:0] prime_count,
  input  logic                      finished,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [lps_pkg::VAL_W-1:0] sieve_limit,
  output int                        errors,
  output int                        pending
);
  import lps_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] cand;
    logic             prime;
    logic [CNT_W-1:0] count;
    logic             fin;
  } sieve_out_t;

  logic [VAL_W-1:0]  factor_of [0:TBL_DEPTH-1];
  logic [VAL_W-1:0]  primes [0:PRIME_SLOTS-1];
  logic [CAND_W-1:0] next_cand;
  logic [CNT_W-1:0]  found;
  logic [VAL_W-1:0]  lim;
  sieve_out_t        sieve_out_q [$];
  int                nerr;

  task automatic clear_sieve();
    for (int i = 0; i < TBL_DEPTH; i++) factor_of[i] = '0;
    next_cand = CAND_W'(2);
    found     = '0;
  endtask

  task automatic sieve_step(input logic rs, output sieve_out_t r);
    int unsigned c, f, p, prod;
    if (rs) clear_sieve();
    r = '0;
    c = next_cand;
    if (c > lim) begin
      // past the limit, nothing changes
      r.count = found;
      r.fin   = 1'b1;
      return;
    end
    if (factor_of[c] == '0) begin
      r.prime      = 1'b1;
      factor_of[c] = VAL_W'(c);
      if (found < PRIME_SLOTS) begin
        primes[found] = VAL_W'(c);
        found         = found + 1'b1;
      end
    end
    f = factor_of[c];
    for (int unsigned j = 0; j < found; j++) begin
      p    = primes[j];
      prod = c * p;
      if (p > f || prod > lim) break;
      factor_of[prod] = VAL_W'(p);
    end
    next_cand = CAND_W'(c + 1);
    r.cand    = VAL_W'(c);
    r.count   = found;
  endtask

  task automatic flag(input string what, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      nerr++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp, act);
    end
  endtask

  always @(posedge clk) begin
    sieve_out_t r;
    if (rst) begin
      clear_sieve();
      lim = VAL_W'(MAX_LIMIT);
      sieve_out_q.delete();
      nerr = 0;
    end else begin
      if (cfg_valid && cfg_ready) lim = sieve_limit;
      if (out_valid && !out_stall) begin
        if (sieve_out_q.size() == 0) begin
          nerr++;
          $display("%0t: result with no request, expected none actual candidate %0d",
                   $time, candidate);
        end else begin
          r = sieve_out_q.pop_front();
          flag("candidate", r.cand, candidate);
          flag("prime flag", r.prime, prime_flag);
          flag("prime_count", r.count, prime_count);
          flag("finished", r.fin, finished);
        end
      end
      if (in_valid && !in_stall) begin
        sieve_step(restart, r);
        sieve_out_q.insert(sieve_out_q.size(), r);
      end
    end
    errors  <= nerr;
    pending <= sieve_out_q.size();
  end

endmodule

// ----- bench/tb_linear_prime_sieve_unit.sv -----
`timescale 1ns / 1ps

module tb_linear_prime_sieve_unit;
  import lps_pkg::*;

  localparam int WATCHDOG = 30000;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic             restart;
  logic             out_valid;
  logic             out_stall;
  logic [VAL_W-1:0] candidate;
  logic             prime_flag;
  logic [CNT_W-1:0] prime_count;
  logic             finished;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [VAL_W-1:0] sieve_limit;
  int               errors;
  int               pending;
  int               idle_cycles = 0;
  int               reqs_sent;
  int               cur_lim;
  bit               in_burst;

  linear_prime_sieve_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .candidate  (candidate),
    .prime_flag (prime_flag),
    .prime_count(prime_count),
    .finished   (finished),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .sieve_limit(sieve_limit)
  );

  lps_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .candidate  (candidate),
    .prime_flag (prime_flag),
    .prime_count(prime_count),
    .finished   (finished),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .sieve_limit(sieve_limit),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("tb_linear_prime_sieve_unit: errors");
        $finish;
      end
    end
  end

  // result side backpressure
  initial begin
    int w;
    int n;
    bit out_burst;
    out_stall = 1'b0;
    out_burst = 1'b0;
    n = 0;
    forever begin
      if (n % 25 == 0) out_burst = ($urandom_range(0, 3) == 0);
      n++;
      w = out_burst ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (w - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_req(input logic rs);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      restart  <= 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
    reqs_sent++;
  endtask

  task automatic send_batch(input logic first_rs, input int n, input bit noisy);
    logic rs;
    for (int i = 0; i < n; i++) begin
      if (i == 0) rs = first_rs;
      else rs = noisy && ($urandom_range(0, 31) == 0);
      send_req(rs);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_limit(input int v);
    drain();
    @(negedge clk);
    cfg_valid   <= 1'b1;
    sieve_limit <= VAL_W'(v);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid   <= 1'b0;
    sieve_limit <= VAL_W'($urandom);
    cur_lim = v;
  endtask

  initial begin
    int v;
    rst         = 1'b1;
    in_valid    = 1'b0;
    restart     = 1'b0;
    cfg_valid   = 1'b0;
    sieve_limit = '0;
    reqs_sent   = 0;
    cur_lim     = MAX_LIMIT;
    in_burst    = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: run from reset, restart mid-run, tiny limits, raised limit
    send_batch(1'b0, 6, 1'b0);
    send_batch(1'b1, 3, 1'b0);
    set_limit(0);
    send_batch(1'b0, 2, 1'b0);
    set_limit(1);
    send_batch(1'b1, 1, 1'b0);
    set_limit(2);
    send_batch(1'b1, 3, 1'b0);
    set_limit(10);
    send_batch(1'b0, 4, 1'b0);
    set_limit(MAX_LIMIT);
    send_batch(1'b1, 5, 1'b0);

    while (reqs_sent < 400) begin
      in_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: begin
          set_limit($urandom_range(0, 3));
          send_batch(1'($urandom_range(0, 1)), $urandom_range(1, 4), 1'b1);
        end
        1: begin
          set_limit(MAX_LIMIT);
          send_batch(1'b1, $urandom_range(10, 30), 1'b1);
        end
        2: begin
          v = cur_lim + $urandom_range(1, 60);
          if (v > MAX_LIMIT) v = MAX_LIMIT;
          set_limit(v);
          send_batch(1'b0, $urandom_range(3, 20), 1'b1);
        end
        default: begin
          v = $urandom_range(4, 80);
          set_limit(v);
          send_batch($urandom_range(0, 4) != 0, v - 1 + $urandom_range(0, 2), 1'b1);
        end
      endcase
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_linear_prime_sieve_unit: clean");
    end else begin
      $display("tb_linear_prime_sieve_unit: errors");
    end
    $finish;
  end

endmodule
